[hdl/dac_pkg.sv]
// ----------------------------------------------------------------------------
// dac_pkg: shared types and constants for the directory CRC and lookup block
// Transaction structs, register indexes and CRC constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dac_pkg;

   // Directory size limit, used as the default of the top-level parameter
   localparam int unsigned MAX_DIR_BYTES_DEFAULT = 48;

   // CRC-8 settings: polynomial x^8 + x^4 + x^3 + x^2 + 1, MSB first
   localparam logic [7:0] CRC_POLY  = 8'h1D;
   localparam logic [7:0] CRC_START = 8'hC7;

   // Offset added to the sector number for the second directory
   localparam logic [5:0] SECOND_OFFSET = 6'd16;

   // Configuration port
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_APP_ID    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_DIRECTORY = 1'd1;

   // Input transaction: one directory byte
   typedef struct packed {
      logic [7:0] dir_byte;
      logic       last_byte;
   } req_type;

   // Result transaction: checksum and lookup outcome
   typedef struct packed {
      logic       crc_ok;
      logic [7:0] computed_crc;
      logic       found;
      logic [5:0] sector_number;
   } rsp_type;

endpackage

[hdl/directory_crc_and_lookup.sv]
// ----------------------------------------------------------------------------
// directory_crc_and_lookup: directory checksum check and application lookup
// Takes one directory byte per cycle while the result register is empty or being taken;
// a pending result that is not taken stalls the input. The result is registered and
// appears in the cycle after the byte marked last is taken. The CRC byte update is combinational.
// Reset (synchronous) clears the configuration, the directory state and the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module directory_crc_and_lookup #(
   parameter int unsigned MAX_DIR_BYTES = dac_pkg::MAX_DIR_BYTES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dac_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dac_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // directory bytes
   input  logic                               req_valid,
   output logic                               req_ready,
   input  dac_pkg::req_type                   req_data,
   // results
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output dac_pkg::rsp_type                   rsp_data
);

   localparam int unsigned IDX_W = $clog2(MAX_DIR_BYTES + 1);
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_DIR_BYTES);
   localparam logic [IDX_W-1:0] IDX_FIRST_PAIR = IDX_W'(3);

   // Configuration registers
   logic [15:0] target_app_id_ff, target_app_id_in;
   logic        second_directory_ff, second_directory_in;

   // Directory state
   logic [IDX_W-1:0] byte_index_ff, byte_index_in;
   logic [7:0]       running_crc_ff, running_crc_in;
   logic [7:0]       stored_crc_ff, stored_crc_in;
   logic [7:0]       previous_byte_ff, previous_byte_in;
   logic             match_seen_ff, match_seen_in;
   logic [5:0]       match_sector_ff, match_sector_in;

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   dac_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic       req_take;
   logic       in_range;
   logic [7:0] crc_upd;
   logic       pair_hit;
   logic [5:0] sector_sel;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Decode configuration writes
   always_comb begin
      target_app_id_in    = target_app_id_ff;
      second_directory_in = second_directory_ff;
      if (csr_valid) begin
         unique case (csr_index)
            dac_pkg::CSR_TARGET_APP_ID:    target_app_id_in    = csr_wdata;
            dac_pkg::CSR_SECOND_DIRECTORY: second_directory_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   dac_crc8 u_crc8 (
      .crc_cur   (running_crc_ff),
      .data_byte (req_data.dir_byte),
      .crc_next  (crc_upd)
   );

   assign in_range = byte_index_ff < IDX_MAX;
   // A pair completes on every odd index from three on
   assign pair_hit = in_range && (byte_index_ff >= IDX_FIRST_PAIR) && byte_index_ff[0]
                     && !match_seen_ff
                     && ({req_data.dir_byte, previous_byte_ff} == target_app_id_in);

   // Advance the directory state for one byte, clear it after the last one
   always_comb begin
      byte_index_in    = byte_index_ff;
      running_crc_in   = running_crc_ff;
      stored_crc_in    = stored_crc_ff;
      previous_byte_in = previous_byte_ff;
      match_seen_in    = match_seen_ff;
      match_sector_in  = match_sector_ff;
      if (req_take && in_range) begin
         if (byte_index_ff == '0) begin
            stored_crc_in = req_data.dir_byte;
         end else begin
            running_crc_in = crc_upd;
         end
         if (pair_hit) begin
            match_seen_in   = 1'b1;
            match_sector_in = 6'(byte_index_ff >> 1);
         end
         previous_byte_in = req_data.dir_byte;
         byte_index_in    = byte_index_ff + IDX_W'(1);
      end
   end

   // Build the result from the updated state
   always_comb begin
      sector_sel = '0;
      if (match_seen_in) begin
         sector_sel = second_directory_ff ? match_sector_in + dac_pkg::SECOND_OFFSET
                                          : match_sector_in;
      end
      rsp_data_in.crc_ok        = running_crc_in == stored_crc_in;
      rsp_data_in.computed_crc  = running_crc_in;
      rsp_data_in.found         = match_seen_in;
      rsp_data_in.sector_number = sector_sel;
   end

   // Hold the result until taken, load a new one on a last byte
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_take && req_data.last_byte) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_app_id_ff    <= '0;
         second_directory_ff <= 1'b0;
         byte_index_ff       <= '0;
         running_crc_ff      <= dac_pkg::CRC_START;
         stored_crc_ff       <= '0;
         previous_byte_ff    <= '0;
         match_seen_ff       <= 1'b0;
         match_sector_ff     <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         target_app_id_ff    <= target_app_id_in;
         second_directory_ff <= second_directory_in;
         rsp_valid_ff        <= rsp_valid_in;
         if (req_take && req_data.last_byte) begin
            byte_index_ff    <= '0;
            running_crc_ff   <= dac_pkg::CRC_START;
            stored_crc_ff    <= '0;
            previous_byte_ff <= '0;
            match_seen_ff    <= 1'b0;
            match_sector_ff  <= '0;
         end else begin
            byte_index_ff    <= byte_index_in;
            running_crc_ff   <= running_crc_in;
            stored_crc_ff    <= stored_crc_in;
            previous_byte_ff <= previous_byte_in;
            match_seen_ff    <= match_seen_in;
            match_sector_ff  <= match_sector_in;
         end
      end
   end

   // Load result payload with each new result
   always_ff @(posedge clock) begin
      if (req_take && req_data.last_byte) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

[hdl/dac_crc8.sv]
// ----------------------------------------------------------------------------
// dac_crc8: one-byte CRC-8 update
// Folds one data byte into the running CRC, eight shift steps unrolled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dac_crc8 (
   input  logic [7:0] crc_cur,
   input  logic [7:0] data_byte,
   output logic [7:0] crc_next
);

   // Shift out eight bits, folding in the polynomial on a set top bit
   always_comb begin
      logic [7:0] c;
      c = crc_cur ^ data_byte;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ dac_pkg::CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      crc_next = c;
   end

endmodule

[hdl/dac_checker.sv]
// ----------------------------------------------------------------------------
// dac_checker: port-level checks for directory_crc_and_lookup
// Watches the handshakes and result fields of the top level over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dac_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input dac_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input dac_pkg::rsp_type rsp_data
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   // With the result slot empty, input is always taken
   a_req_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with no pending result");

   // A new result only follows a taken last byte
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_data.last_byte))
      else $error("result without a last byte");

   // No sector number without a match
   a_sector_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.sector_number == 6'd0)
      else $error("sector number set without a match");

   // Reset empties the result slot
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind directory_crc_and_lookup dac_checker u_dac_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
